>>> rtl/core/jrt_pkg.sv
// Shared constants, codes and state type for the jagged row table.
`timescale 1ns / 1ps
package jrt_pkg;
	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLUMNS = 64;

	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int CNT_W   = $clog2(MAX_ROWS + 1);
	localparam int COL_W   = $clog2(MAX_COLUMNS);
	localparam int LEN_W   = $clog2(MAX_COLUMNS + 1);
	localparam int IDX_W   = 6;
	localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int CELL_AW = ROW_W + COL_W;
	localparam int OCNT_W  = 7;

	localparam logic [2:0] CMD_APPEND    = 3'd0;
	localparam logic [2:0] CMD_INSERT    = 3'd1;
	localparam logic [2:0] CMD_DELETE    = 3'd2;
	localparam logic [2:0] CMD_READ_ROW  = 3'd3;
	localparam logic [2:0] CMD_READ_ELEM = 3'd4;
	localparam logic [2:0] CMD_CLEAR     = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_LONG  = 2'd2;
	localparam logic [1:0] ST_INDEX = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FREE_RD,
		S_FREE_WT,
		S_SH_RD,
		S_SH_WR,
		S_PUT,
		S_COPY,
		S_MAP_RD,
		S_MAP_WT,
		S_LEN_WT,
		S_DEL_RD,
		S_DEL_WR,
		S_DEL_PUT,
		S_CELL_RD,
		S_CELL_WT,
		S_EMIT
	} state_t;
endpackage

>>> rtl/core/jrt_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module jrt_ram #(
	parameter int DW = 8,
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/jagged_row_table.sv
// Top level of the jagged row table: command sequencer around the row map and cell memories.
//
// Usage: commands arrive on the cmd channel (cmd_valid/cmd_ready), results leave on the
// res channel (res_valid/res_ready). Append and insert bytes are staged one per transfer;
// the transfer with row_end set commits the row. Rows are reached through a row map
// (logical index to physical slot), so insert and delete move map entries, not cells.
// Steps from the command transfer to the result, one command at a time:
//   staged byte without row_end: no result.
//   commit: free slot read, shift of the rows moved down, map and length write, copy.
//   delete: map and length read, shift of the rows moved up, map write.
//   read row/element: map and length read, then cell reads; clear: no memory access.
// The next command is taken in the cycle after the final result is loaded.
// The shift loop over the row map reads and writes one entry at a time on its single
// read port, and the staging copy moves one byte a cycle.
// Reset clears the row count, staging length and row map; no clearing pass is needed.
// The final result sits in the output register while the next command is taken; a
// stalled receiver holds the sequencer in its emit step until the result is taken.
`timescale 1ns / 1ps
module jagged_row_table
	import jrt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [2:0]        command,
	input  logic [5:0]        row_index,
	input  logic [5:0]        column_index,
	input  logic [7:0]        byte_in,
	input  logic              byte_valid,
	input  logic              row_end,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [7:0]        byte_out,
	output logic              byte_out_valid,
	output logic              last_out,
	output logic [1:0]        status,
	output logic [6:0]        row_count,
	output logic [6:0]        column_count
);
	state_t state_q, state_d;

	logic [CNT_W-1:0] rows_q;
	logic [LEN_W-1:0] stg_len_q;
	logic             stg_ovf_q;
	logic [2:0]       cmd_q;
	logic [CNT_W-1:0] pos_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] slot_q;
	logic [CNT_W-1:0] idx_q;
	logic [LEN_W-1:0] ccnt_q;
	logic [LEN_W-1:0] len_q;
	logic             cp_v_s1;
	logic [COL_W-1:0] cp_col_s1;
	logic [MAX_ROWS-1:0] mvalid_q;
	logic [ROW_W-1:0] mraddr_s1;

	logic [7:0]       pend_byte_q;
	logic             pend_bv_q;
	logic             pend_last_q;
	logic [1:0]       pend_st_q;
	logic [LEN_W-1:0] pend_cols_q;

	logic             res_valid_q;
	logic [7:0]       byte_out_q;
	logic             byte_out_valid_q;
	logic             last_out_q;
	logic [1:0]       status_q;
	logic [6:0]       row_count_q;
	logic [6:0]       column_count_q;

	// memory ports
	logic             map_we;
	logic [ROW_W-1:0] map_waddr, map_raddr, map_wdata, map_rdata, map_eff;
	logic             len_we;
	logic [ROW_W-1:0] len_waddr, len_raddr;
	logic [LEN_W-1:0] len_wdata, len_rdata;
	logic             cell_we;
	logic [CELL_AW-1:0] cell_waddr, cell_raddr;
	logic [7:0]       cell_rdata;
	logic             stg_we;
	logic [COL_W-1:0] stg_waddr, stg_raddr;
	logic [7:0]       stg_rdata;

	// accept-time decode
	logic             accept, is_byte, stg_room, row_bad, load, copy_done, copy_step;
	logic [LEN_W-1:0] new_len;
	logic             new_ovf;
	logic [1:0]       commit_st;

	jrt_ram #(.DW(ROW_W), .AW(ROW_W)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.raddr(map_raddr), .rdata(map_rdata)
	);
	jrt_ram #(.DW(LEN_W), .AW(ROW_W)) u_len (
		.clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
		.raddr(len_raddr), .rdata(len_rdata)
	);
	jrt_ram #(.DW(8), .AW(CELL_AW)) u_cell (
		.clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(stg_rdata),
		.raddr(cell_raddr), .rdata(cell_rdata)
	);
	jrt_ram #(.DW(8), .AW(COL_W)) u_stg (
		.clk(clk), .we(stg_we), .waddr(stg_waddr), .wdata(byte_in),
		.raddr(stg_raddr), .rdata(stg_rdata)
	);

	// an unwritten map entry stands for the identity mapping
	assign map_eff = mvalid_q[mraddr_s1] ? map_rdata : mraddr_s1;

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign is_byte   = (command == CMD_APPEND) || (command == CMD_INSERT);
	assign stg_room  = (stg_len_q < LEN_W'(MAX_COLUMNS));
	assign new_len   = (byte_valid && stg_room) ? stg_len_q + 1'b1 : stg_len_q;
	assign new_ovf   = stg_ovf_q || (byte_valid && !stg_room);
	assign row_bad   = CMP_W'(row_index) >= CMP_W'(rows_q);
	assign load      = (state_q == S_EMIT) && (!res_valid_q || res_ready);
	assign copy_step = (state_q == S_COPY) && (ccnt_q < stg_len_q);
	assign copy_done = (state_q == S_COPY) && (ccnt_q == stg_len_q) && !cp_v_s1;

	always_comb begin
		if (CNT_W'(MAX_ROWS) <= rows_q) begin
			commit_st = ST_FULL;
		end else if (new_ovf) begin
			commit_st = ST_LONG;
		end else if ((command == CMD_INSERT) && (CMP_W'(row_index) > CMP_W'(rows_q))) begin
			commit_st = ST_INDEX;
		end else begin
			commit_st = ST_OK;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_byte) begin
						if (row_end) begin
							state_d = (commit_st == ST_OK) ? S_FREE_RD : S_EMIT;
						end
					end else if ((command == CMD_DELETE) || (command == CMD_READ_ROW)
							|| (command == CMD_READ_ELEM)) begin
						state_d = row_bad ? S_EMIT : S_MAP_RD;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_FREE_RD: state_d = S_FREE_WT;
			S_FREE_WT: state_d = (rows_q > pos_q) ? S_SH_RD : S_PUT;
			S_SH_RD:   state_d = S_SH_WR;
			S_SH_WR:   state_d = ((idx_q - 1'b1) > pos_q) ? S_SH_RD : S_PUT;
			S_PUT:     state_d = S_COPY;
			S_COPY:    state_d = copy_done ? S_EMIT : S_COPY;
			S_MAP_RD:  state_d = S_MAP_WT;
			S_MAP_WT:  state_d = S_LEN_WT;
			S_LEN_WT: begin
				case (cmd_q)
					CMD_DELETE:
						state_d = ((idx_q + 1'b1) < rows_q) ? S_DEL_RD : S_DEL_PUT;
					CMD_READ_ROW:
						state_d = (len_rdata == '0) ? S_EMIT : S_CELL_RD;
					default:
						state_d = (OCNT_W'(col_q) >= OCNT_W'(len_rdata)) ? S_EMIT : S_CELL_RD;
				endcase
			end
			S_DEL_RD:  state_d = S_DEL_WR;
			S_DEL_WR:  state_d = ((idx_q + 2'd2) < rows_q) ? S_DEL_RD : S_DEL_PUT;
			S_DEL_PUT: state_d = S_EMIT;
			S_CELL_RD: state_d = S_CELL_WT;
			S_CELL_WT: state_d = S_EMIT;
			S_EMIT: begin
				if (load) begin
					state_d = pend_last_q ? S_IDLE : S_CELL_RD;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		map_we    = 1'b0;
		map_waddr = idx_q[ROW_W-1:0];
		map_wdata = map_eff;
		map_raddr = idx_q[ROW_W-1:0];
		len_we    = 1'b0;
		len_waddr = slot_q;
		len_wdata = stg_len_q;
		len_raddr = map_eff;
		stg_we    = accept && is_byte && byte_valid && stg_room;
		stg_waddr = stg_len_q[COL_W-1:0];
		stg_raddr = ccnt_q[COL_W-1:0];
		cell_we    = cp_v_s1;
		cell_waddr = {slot_q, cp_col_s1};
		cell_raddr = {slot_q, ccnt_q[COL_W-1:0]};
		case (state_q)
			S_FREE_RD: map_raddr = rows_q[ROW_W-1:0];
			S_SH_RD:   map_raddr = ROW_W'(idx_q - 1'b1);
			S_SH_WR:   map_we = 1'b1;
			S_PUT: begin
				map_we    = 1'b1;
				map_waddr = pos_q[ROW_W-1:0];
				map_wdata = slot_q;
				len_we    = 1'b1;
			end
			S_MAP_RD:  map_raddr = pos_q[ROW_W-1:0];
			S_DEL_RD:  map_raddr = ROW_W'(idx_q + 1'b1);
			S_DEL_WR:  map_we = 1'b1;
			S_DEL_PUT: begin
				map_we    = 1'b1;
				map_waddr = ROW_W'(rows_q - 1'b1);
				map_wdata = slot_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rows_q      <= '0;
			stg_len_q   <= '0;
			stg_ovf_q   <= 1'b0;
			mvalid_q    <= '0;
			cp_v_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cp_v_s1 <= copy_step;
			if (map_we) begin
				mvalid_q[map_waddr] <= 1'b1;
			end
			if (accept && is_byte) begin
				if (row_end && (commit_st != ST_OK)) begin
					stg_len_q <= '0;
					stg_ovf_q <= 1'b0;
				end else begin
					stg_len_q <= new_len;
					stg_ovf_q <= new_ovf;
				end
			end
			if (accept && (command == CMD_CLEAR)) begin
				rows_q <= '0;
			end
			if (copy_done) begin
				rows_q    <= rows_q + 1'b1;
				stg_len_q <= '0;
				stg_ovf_q <= 1'b0;
			end
			if (state_q == S_DEL_PUT) begin
				rows_q <= rows_q - 1'b1;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mraddr_s1 <= map_raddr;
		cp_col_s1 <= ccnt_q[COL_W-1:0];
		if (accept) begin
			cmd_q       <= command;
			col_q       <= COL_W'(column_index);
			pos_q       <= (command == CMD_APPEND) ? rows_q : CNT_W'(row_index);
			idx_q       <= CNT_W'(row_index);
			pend_byte_q <= '0;
			pend_bv_q   <= 1'b0;
			pend_last_q <= 1'b1;
			pend_cols_q <= '0;
			if (is_byte) begin
				pend_st_q <= commit_st;
			end else if ((command == CMD_DELETE) || (command == CMD_READ_ROW)
					|| (command == CMD_READ_ELEM)) begin
				pend_st_q <= row_bad ? ST_INDEX : ST_OK;
			end else if (command == CMD_CLEAR) begin
				pend_st_q <= ST_OK;
			end else begin
				pend_st_q <= ST_INDEX;
			end
		end
		case (state_q)
			S_FREE_WT: begin
				slot_q <= map_eff;
				idx_q  <= rows_q;
			end
			S_SH_WR:   idx_q <= idx_q - 1'b1;
			S_PUT:     ccnt_q <= '0;
			S_COPY: begin
				if (copy_step) begin
					ccnt_q <= ccnt_q + 1'b1;
				end
				if (copy_done) begin
					pend_cols_q <= stg_len_q;
				end
			end
			S_MAP_WT:  slot_q <= map_eff;
			S_LEN_WT: begin
				len_q       <= len_rdata;
				pend_cols_q <= len_rdata;
				if (cmd_q == CMD_READ_ELEM) begin
					ccnt_q <= LEN_W'(col_q);
					if (OCNT_W'(col_q) >= OCNT_W'(len_rdata)) begin
						pend_st_q <= ST_INDEX;
					end
				end else begin
					ccnt_q <= '0;
				end
			end
			S_DEL_WR:  idx_q <= idx_q + 1'b1;
			S_CELL_WT: begin
				pend_byte_q <= cell_rdata;
				pend_bv_q   <= 1'b1;
				pend_last_q <= (cmd_q == CMD_READ_ELEM) || ((ccnt_q + 1'b1) == len_q);
			end
			S_EMIT: begin
				if (load && !pend_last_q) begin
					ccnt_q <= ccnt_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (load) begin
			byte_out_q       <= pend_byte_q;
			byte_out_valid_q <= pend_bv_q;
			last_out_q       <= pend_last_q;
			status_q         <= pend_st_q;
			row_count_q      <= OCNT_W'(rows_q);
			column_count_q   <= OCNT_W'(pend_cols_q);
		end
	end

	assign res_valid      = res_valid_q;
	assign byte_out       = byte_out_q;
	assign byte_out_valid = byte_out_valid_q;
	assign last_out       = last_out_q;
	assign status         = status_q;
	assign row_count      = row_count_q;
	assign column_count   = column_count_q;

`ifndef SYNTHESIS
	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q <= CNT_W'(MAX_ROWS))
		else $error("row count beyond table size");
	a_stg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stg_len_q <= LEN_W'(MAX_COLUMNS))
		else $error("staging length beyond row size");
	a_copy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY) |-> (ccnt_q <= stg_len_q))
		else $error("staging copy ran past staged length");
	a_del_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEL_PUT) |-> (rows_q != '0))
		else $error("delete on empty table");
	a_stream_next: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !pend_last_q) |=> (state_q == S_CELL_RD))
		else $error("row stream did not advance");
`endif
endmodule

>>> tb/sv/jrt_checker.sv
// Checker for the jagged row table: predicts results per command and compares them.
`timescale 1ns / 1ps
module jrt_checker
	import jrt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  logic       cmd_ready,
	input  logic [2:0] command,
	input  logic [5:0] row_index,
	input  logic [5:0] column_index,
	input  logic [7:0] byte_in,
	input  logic       byte_valid,
	input  logic       row_end,
	input  logic       res_valid,
	input  logic       res_ready,
	input  logic [7:0] byte_out,
	input  logic       byte_out_valid,
	input  logic       last_out,
	input  logic [1:0] status,
	input  logic [6:0] row_count,
	input  logic [6:0] column_count,
	output int         fail_count,
	output int         pending
);
	typedef struct packed {
		logic [7:0] data;
		logic       data_valid;
		logic       last;
		logic [1:0] stat;
		logic [6:0] rows;
		logic [6:0] cols;
	} table_result_t;

	logic [7:0] rows_mem [MAX_ROWS][MAX_COLUMNS];
	logic [6:0] len_mem [MAX_ROWS];
	int         rows_held;
	logic [7:0] stage [MAX_COLUMNS];
	int         stage_len;
	bit         stage_over;
	table_result_t expected_results [$];

	assign pending = expected_results.size();

	function automatic void push_result(logic [7:0] d, logic dv, logic l, logic [1:0] s,
			int c);
		table_result_t r;
		r.data = d; r.data_valid = dv; r.last = l; r.stat = s;
		r.rows = 7'(rows_held); r.cols = 7'(c);
		expected_results.push_back(r);
	endfunction

	function automatic void predict_command(logic [2:0] cmd, int ri, int ci, logic [7:0] b,
			logic bv, logic re);
		logic [1:0] s;
		int         n;
		int         pos;
		case (cmd)
			CMD_APPEND, CMD_INSERT: begin
				if (bv) begin
					if (stage_len < MAX_COLUMNS) begin
						stage[stage_len] = b;
						stage_len++;
					end else
						stage_over = 1;
				end
				if (re) begin
					n = stage_len;
					s = ST_OK;
					if (rows_held >= MAX_ROWS) s = ST_FULL;
					else if (stage_over) s = ST_LONG;
					else if (cmd == CMD_INSERT && ri > rows_held) s = ST_INDEX;
					if (s == ST_OK) begin
						pos = (cmd == CMD_INSERT) ? ri : rows_held;
						for (int r = rows_held; r > pos; r--) begin
							rows_mem[r] = rows_mem[r-1];
							len_mem[r] = len_mem[r-1];
						end
						for (int c = 0; c < n; c++) rows_mem[pos][c] = stage[c];
						len_mem[pos] = 7'(n);
						rows_held++;
					end
					stage_len = 0;
					stage_over = 0;
					push_result(0, 0, 1, s, s == ST_OK ? n : 0);
				end
			end
			CMD_DELETE: begin
				if (ri >= rows_held) push_result(0, 0, 1, ST_INDEX, 0);
				else begin
					n = len_mem[ri];
					for (int r = ri; r < rows_held - 1; r++) begin
						rows_mem[r] = rows_mem[r+1];
						len_mem[r] = len_mem[r+1];
					end
					rows_held--;
					push_result(0, 0, 1, ST_OK, n);
				end
			end
			CMD_READ_ROW: begin
				if (ri >= rows_held) push_result(0, 0, 1, ST_INDEX, 0);
				else begin
					n = len_mem[ri];
					if (n == 0) push_result(0, 0, 1, ST_OK, 0);
					for (int c = 0; c < n; c++)
						push_result(rows_mem[ri][c], 1, c + 1 == n, ST_OK, n);
				end
			end
			CMD_READ_ELEM: begin
				if (ri >= rows_held) push_result(0, 0, 1, ST_INDEX, 0);
				else begin
					n = len_mem[ri];
					if (ci >= n) push_result(0, 0, 1, ST_INDEX, n);
					else push_result(rows_mem[ri][ci], 1, 1, ST_OK, n);
				end
			end
			CMD_CLEAR: begin
				rows_held = 0;
				push_result(0, 0, 1, ST_OK, 0);
			end
			default: push_result(0, 0, 1, ST_INDEX, 0);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_result_t e;
		if (!arst_n) begin
			rows_held = 0;
			stage_len = 0;
			stage_over = 0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with nothing expected");
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (byte_out !== e.data) begin
						$error("byte_out exp %0d got %0d", e.data, byte_out); fail_count++;
					end
					if (byte_out_valid !== e.data_valid) begin
						$error("byte_out_valid exp %0d got %0d", e.data_valid, byte_out_valid);
						fail_count++;
					end
					if (last_out !== e.last) begin
						$error("last_out exp %0d got %0d", e.last, last_out); fail_count++;
					end
					if (status !== e.stat) begin
						$error("status exp %0d got %0d", e.stat, status); fail_count++;
					end
					if (row_count !== e.rows) begin
						$error("row_count exp %0d got %0d", e.rows, row_count); fail_count++;
					end
					if (column_count !== e.cols) begin
						$error("column_count exp %0d got %0d", e.cols, column_count);
						fail_count++;
					end
				end
			end
			if (cmd_valid && cmd_ready)
				predict_command(command, row_index, column_index, byte_in, byte_valid,
					row_end);
		end
	end
endmodule

>>> tb/sv/tb_jagged_row_table.sv
// Testbench top for the jagged row table: stimulus, idling, pressure and verdict.
`timescale 1ns / 1ps
module tb_jagged_row_table;
	import jrt_pkg::*;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       cmd_valid = 0;
	logic       cmd_ready;
	logic [2:0] command = CMD_CLEAR;
	logic [5:0] row_index = 0;
	logic [5:0] column_index = 0;
	logic [7:0] byte_in = 0;
	logic       byte_valid = 0;
	logic       row_end = 0;
	logic       res_valid;
	logic       res_ready = 0;
	logic [7:0] byte_out;
	logic       byte_out_valid;
	logic       last_out;
	logic [1:0] status;
	logic [6:0] row_count;
	logic [6:0] column_count;
	int         fail_count;
	int         pending;
	int         send_idle_pct = 8;
	int         recv_idle_pct = 60;
	int         phase = 0;
	bit         hold_done = 0;
	int         hold_off = 0;
	int         rows_guess = 0;
	longint     cycle_count = 0;

	always #1 clk = ~clk;

	jagged_row_table u_top (.*);

	jrt_checker u_chk (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off at the start of the second phase
	always @(posedge clk) begin
		if ((phase == 1) && !hold_done) begin
			hold_done <= 1;
			hold_off  <= 400;
			res_ready <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			res_ready <= 0;
		end else
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_item(logic [2:0] c, logic [5:0] ri, logic [5:0] ci, logic [7:0] b,
			logic bv, logic re);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 0;
			@(posedge clk);
		end
		cmd_valid <= 1;
		command <= c; row_index <= ri; column_index <= ci;
		byte_in <= b; byte_valid <= bv; row_end <= re;
		do @(posedge clk); while (!cmd_ready);
	endtask

	// stage a whole row of n bytes and commit it
	task automatic send_row(logic [2:0] c, int n, logic [5:0] pos);
		for (int i = 0; i < n; i++)
			send_item(c, pos, 0, 8'($urandom), 1, i == n - 1);
		if (n == 0) send_item(c, pos, 0, 8'($urandom), 0, 1);
	endtask

	task automatic random_item();
		int k;
		k = $urandom_range(99);
		if (k < 35) send_row($urandom_range(1) ? CMD_INSERT : CMD_APPEND,
				$urandom_range(6),
				$urandom_range(100) < 85 ? 6'($urandom_range(rows_guess + 1)) : 6'($urandom));
		else if (k < 50) send_item(CMD_DELETE, $urandom_range(100) < 80 ?
				6'($urandom_range(rows_guess)) : 6'($urandom), 0, 0, 0, 0);
		else if (k < 68) send_item(CMD_READ_ROW, 6'($urandom_range(rows_guess)), 0, 0, 0, 0);
		else if (k < 86) send_item(CMD_READ_ELEM, 6'($urandom_range(rows_guess)),
				$urandom_range(100) < 70 ? 6'($urandom_range(5)) : 6'($urandom), 0, 0, 0);
		else if (k < 90) send_item(CMD_CLEAR, 6'($urandom), 6'($urandom), 8'($urandom),
				1'($urandom), 0);
		else if (k < 94) send_item(3'($urandom_range(6, 7)), 6'($urandom), 6'($urandom),
				8'($urandom), 1'($urandom), 1'($urandom));
		else send_item(3'($urandom_range(1)), 6'($urandom), 6'($urandom), 8'($urandom),
				1'($urandom), 1'($urandom));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty table errors, empty row, long rows, overflow, insert positions
		send_item(CMD_DELETE, 0, 0, 0, 0, 0);
		send_item(CMD_READ_ROW, 0, 0, 0, 0, 0);
		send_item(CMD_READ_ELEM, 0, 0, 0, 0, 0);
		send_item(3'd6, 63, 63, 8'hff, 1, 1);
		send_item(3'd7, 0, 0, 0, 0, 0);
		send_row(CMD_APPEND, 0, 0);
		send_row(CMD_APPEND, 3, 0);
		send_item(CMD_APPEND, 0, 0, 8'h00, 1, 0);
		send_item(CMD_APPEND, 0, 0, 8'hff, 1, 1);
		send_row(CMD_INSERT, 2, 5);
		send_row(CMD_INSERT, 2, 0);
		send_row(CMD_INSERT, 4, 1);
		send_row(CMD_APPEND, 65, 0);
		send_item(CMD_READ_ROW, 1, 0, 0, 0, 0);
		send_item(CMD_READ_ROW, 3, 0, 0, 0, 0);
		send_item(CMD_READ_ELEM, 3, 63, 0, 0, 0);
		send_item(CMD_READ_ELEM, 3, 0, 0, 0, 0);
		send_item(CMD_READ_ELEM, 63, 0, 0, 0, 0);
		send_item(CMD_DELETE, 1, 0, 0, 0, 0);
		send_item(CMD_APPEND, 0, 0, 8'h5a, 1, 0);
		send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
		send_item(CMD_APPEND, 0, 0, 8'ha5, 1, 1);
		// fill the table to the top and push one more
		for (int i = 0; i < 63; i++) send_item(CMD_APPEND, 0, 0, 8'(i), 1'($urandom), 1);
		send_item(CMD_APPEND, 0, 0, 0, 0, 1);
		send_item(CMD_DELETE, 63, 0, 0, 0, 0);
		send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
		rows_guess = 0;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 60 : 0;
			recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 8 : 0;
			phase = ph;
			for (int i = 0; i < 4; i++) begin
				random_item();
				if (rows_guess < 8) rows_guess++;
			end
		end
		cmd_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
